// File: design/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types and constants of the bandwidth admission control unit:
// status codes, operation and domain codes, register indexes, field widths.
// ----------------------------------------------------------------------------
package bac_pkg;

    // Field widths
    localparam int DIV_W   = 64;  // budget, period, scaled product, quotient
    localparam int SHARE_W = 32;  // computed share before truncation
    localparam int ADM_W   = 21;  // admitted sum, limit, reported share
    localparam int RSV_W   = 20;  // reserved share
    localparam int CNT_W   = 7;   // cpu count
    localparam int CPU_W   = 6;   // cpu field
    localparam int CFGI_W  = 2;   // configuration register index

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_BADCPU    = 3'd3,
        ST_BUSY      = 3'd4,
        ST_CAPACITY  = 3'd5,
        ST_UNDERFLOW = 3'd6
    } t_status;

    // Operation codes (any other code is a query)
    localparam logic [1:0] OP_ADMIT   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;

    // Context membership codes
    localparam logic [1:0] DOM_NONE = 2'd0;
    localparam logic [1:0] DOM_THIS = 2'd1;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_SHARE_LIMIT    = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_RESERVED_SHARE = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_CPU_COUNT      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [ADM_W-1:0] LIMIT_RST = 21'd1048576;
    localparam logic [RSV_W-1:0] RSV_RST   = 20'd0;
    localparam logic [CNT_W-1:0] COUNT_RST = 7'd64;

    // Result of the share unit
    typedef struct packed {
        logic                 done;
        t_status              status;
        logic [SHARE_W-1:0]   share;
    } t_div_res;

endpackage

// File: design/bac_share_div.sv
// ----------------------------------------------------------------------------
// bac_share_div
// Share unit: scales the budget with one shared 32x32 multiplier, low half
// then high half, then runs a restoring divider one quotient bit per cycle
// and rounds up. Flags overflow, a zero period and a share outside 1..scale.
// ----------------------------------------------------------------------------
module bac_share_div #(
    parameter int unsigned UNIT_SCALE = 1048576
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bac_pkg::DIV_W-1:0]         i_budget,
    input  logic [bac_pkg::DIV_W-1:0]         i_period,
    output bac_pkg::t_div_res                 o_res
);

    localparam int DW = bac_pkg::DIV_W;
    localparam int HW = DW / 2;
    localparam int CW = $clog2(DW);
    localparam logic [DW-1:0] SCALE_Q   = DW'(UNIT_SCALE);
    localparam logic [HW-1:0] SCALE_H   = HW'(UNIT_SCALE);
    localparam logic [DW-1:0] OVF_LIMIT = {DW{1'b1}} / DW'(UNIT_SCALE);
    localparam logic [CW-1:0] LAST_BIT  = CW'(DW - 1);

    typedef enum logic [2:0] {
        D_IDLE,
        D_MLO,
        D_MHI,
        D_SUM,
        D_DIV,
        D_FIN
    } t_dstate;

    t_dstate           r_state;
    logic [DW-1:0]     r_budget;
    logic [DW-1:0]     r_period;
    logic              r_ovf;
    logic [DW-1:0]     r_acc;
    logic [DW-1:0]     r_prod;
    logic [DW-1:0]     r_quo;
    logic [DW-1:0]     r_rem;
    logic [CW-1:0]     r_cnt;
    bac_pkg::t_div_res r_res;

    logic [HW-1:0]     mul_a;
    logic [DW-1:0]     mul_p;
    logic [DW:0]       shifted;
    logic [DW+1:0]     diff;
    logic              ge;
    logic [DW-1:0]     q_ceil;

    // Share one multiplier between the two budget halves
    assign mul_a = (r_state == D_MHI) ? r_budget[DW-1:HW] : r_budget[HW-1:0];
    assign mul_p = DW'(mul_a) * DW'(SCALE_H);

    // One restoring step
    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_period};
    assign ge      = ~diff[DW+1];

    // Round up the quotient
    assign q_ceil  = r_quo + DW'(r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= D_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_budget <= i_budget;
                        r_period <= i_period;
                        r_ovf    <= (i_budget != '0) && (i_budget > OVF_LIMIT);
                        r_state  <= D_MLO;
                    end
                end
                D_MLO: begin
                    r_acc   <= mul_p;
                    r_state <= D_MHI;
                end
                D_MHI: begin
                    r_prod  <= mul_p;
                    r_state <= D_SUM;
                end
                D_SUM: begin
                    // Upper partial product lands at bit HW and up; overflow is flagged apart
                    r_quo   <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_BIT) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_res.done  <= 1'b1;
                    r_res.share <= '0;
                    if (r_ovf) begin
                        r_res.status <= bac_pkg::ST_OVERFLOW;
                    end else if (r_period == '0) begin
                        r_res.status <= bac_pkg::ST_INVALID;
                    end else if ((q_ceil == '0) || (q_ceil > SCALE_Q)) begin
                        r_res.status <= bac_pkg::ST_INVALID;
                    end else begin
                        r_res.status <= bac_pkg::ST_OK;
                        r_res.share  <= q_ceil[bac_pkg::SHARE_W-1:0];
                    end
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;

endmodule

// File: design/bac_share_mem.sv
// ----------------------------------------------------------------------------
// bac_share_mem
// Admitted-share memory: one 21-bit sum per CPU, one write and one read
// port, registered read data. A clearing pass zeroes every entry after reset.
// ----------------------------------------------------------------------------
module bac_share_mem #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [bac_pkg::ADM_W-1:0]          o_rdata,
    input  logic                               i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [bac_pkg::ADM_W-1:0]          i_wdata,
    output logic                               o_clearing
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [bac_pkg::ADM_W-1:0] mem [DEPTH];
    logic [bac_pkg::ADM_W-1:0] r_rdata;
    logic                      r_clearing;
    logic [AW-1:0]             r_clr_addr;

    logic                      we;
    logic [AW-1:0]             waddr;
    logic [bac_pkg::ADM_W-1:0] wdata;

    // Sweep the clearing address after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Clearing pass takes the write port
    assign we    = r_clearing | i_we;
    assign waddr = r_clearing ? r_clr_addr : i_waddr;
    assign wdata = r_clearing ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// File: design/bandwidth_admission_control_unit.sv
// ----------------------------------------------------------------------------
// bandwidth_admission_control_unit
// Admission control over per-CPU admitted bandwidth: admit, release and
// dispatch query words, with read-modify-write of a per-CPU share memory.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result is out. Admit and release words pass through the share
// unit before the next word can be taken: two multiplies, a sum, a 64-step
// restoring divider at one quotient bit per cycle and a rounding step, with
// the memory read, write-back and result steps around it. Queries skip the
// divider. Each word gives one result, shown for exactly one cycle with
// o_valid high; the receiver must take it then. After reset busy stays high
// while the share memory clears its min(MAX_CPUS, 64) entries. Configuration
// writes are always taken and must only be issued while no word is in flight.
// ----------------------------------------------------------------------------
module bandwidth_admission_control_unit #(
    parameter int unsigned MAX_CPUS   = 64,
    parameter int unsigned UNIT_SCALE = 1048576
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_op,
    input  logic [bac_pkg::CPU_W-1:0]          i_cpu,
    input  logic [bac_pkg::DIV_W-1:0]          i_budget_ticks,
    input  logic [bac_pkg::DIV_W-1:0]          i_period_ticks,
    input  logic                               i_config_valid,
    input  logic [1:0]                         i_context_domain,
    input  logic                               i_context_busy,
    // Result
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic [bac_pkg::ADM_W-1:0]          o_share,
    output logic [bac_pkg::ADM_W-1:0]          o_admitted_total,
    output logic                               o_dispatch_allowed,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bac_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [bac_pkg::ADM_W-1:0]          i_cfg_data
);

    // Only CPU numbers the cpu field can carry need an entry
    localparam int DEPTH = (MAX_CPUS < (2 ** bac_pkg::CPU_W)) ? int'(MAX_CPUS)
                                                               : (2 ** bac_pkg::CPU_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADM_W = bac_pkg::ADM_W;
    localparam int SUM_W = ADM_W + 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DIV,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [1:0]                    r_op;
    logic                          r_cfg_ok;
    logic [1:0]                    r_dom;
    logic                          r_ctx_busy;
    logic                          r_exists;
    logic [AW-1:0]                 r_idx;
    logic [ADM_W-1:0]              r_adm;

    logic [ADM_W-1:0]              r_limit;
    logic [bac_pkg::RSV_W-1:0]     r_reserved;
    logic [bac_pkg::CNT_W-1:0]     r_cpu_count;

    logic                          r_valid;
    bac_pkg::t_status              r_status;
    logic [ADM_W-1:0]              r_share;
    logic [ADM_W-1:0]              r_total;
    logic                          r_allowed;

    logic                          accept;
    logic                          is_rmw;
    logic                          exists;
    logic                          mem_clearing;
    logic [ADM_W-1:0]              mem_rdata;
    bac_pkg::t_div_res             div_res;

    logic [SUM_W-1:0]              cap_sum;
    logic [ADM_W-1:0]              adm_add;
    logic [ADM_W-1:0]              adm_sub;
    bac_pkg::t_status              n_status;
    logic                          n_write;
    logic [ADM_W-1:0]              n_wdata;
    logic                          n_allowed;
    logic [ADM_W-1:0]              n_share;
    logic [ADM_W-1:0]              n_total;

    assign busy        = (r_state != S_IDLE) || mem_clearing;
    assign accept      = start && !busy;
    assign is_rmw      = (i_op == bac_pkg::OP_ADMIT) || (i_op == bac_pkg::OP_RELEASE);
    assign exists      = ({1'b0, i_cpu} < r_cpu_count) && (32'(i_cpu) < MAX_CPUS);
    assign o_cfg_ready = 1'b1;

    // Share unit runs for admit and release words
    bac_share_div #(
        .UNIT_SCALE (UNIT_SCALE)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && is_rmw),
        .i_budget (i_budget_ticks),
        .i_period (i_period_ticks),
        .o_res    (div_res)
    );

    bac_share_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raddr    (r_idx),
        .o_rdata    (mem_rdata),
        .i_we       ((r_state == S_DONE) && n_write),
        .i_waddr    (r_idx),
        .i_wdata    (n_wdata),
        .o_clearing (mem_clearing)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= bac_pkg::LIMIT_RST;
            r_reserved  <= bac_pkg::RSV_RST;
            r_cpu_count <= bac_pkg::COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bac_pkg::CFG_SHARE_LIMIT:    r_limit     <= i_cfg_data;
                bac_pkg::CFG_RESERVED_SHARE: r_reserved  <= i_cfg_data[bac_pkg::RSV_W-1:0];
                bac_pkg::CFG_CPU_COUNT:      r_cpu_count <= i_cfg_data[bac_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Decide the outcome and the write-back value
    assign cap_sum = SUM_W'(r_reserved) + SUM_W'(r_adm) + SUM_W'(div_res.share);
    assign adm_add = r_adm + div_res.share[ADM_W-1:0];
    assign adm_sub = r_adm - div_res.share[ADM_W-1:0];

    always_comb begin
        n_status  = bac_pkg::ST_OK;
        n_write   = 1'b0;
        n_wdata   = r_adm;
        n_allowed = 1'b0;
        case (r_op)
            bac_pkg::OP_ADMIT: begin
                if (!r_cfg_ok) begin
                    n_status = bac_pkg::ST_INVALID;
                end else if (div_res.status != bac_pkg::ST_OK) begin
                    n_status = div_res.status;
                end else if (!r_exists) begin
                    n_status = bac_pkg::ST_BADCPU;
                end else if (r_dom != bac_pkg::DOM_NONE) begin
                    n_status = bac_pkg::ST_BUSY;
                end else if (cap_sum > SUM_W'(r_limit)) begin
                    n_status = bac_pkg::ST_CAPACITY;
                end else begin
                    n_write = 1'b1;
                    n_wdata = adm_add;
                end
            end
            bac_pkg::OP_RELEASE: begin
                if (div_res.status != bac_pkg::ST_OK) begin
                    n_status = div_res.status;
                end else if (r_dom != bac_pkg::DOM_THIS) begin
                    n_status = bac_pkg::ST_INVALID;
                end else if (r_ctx_busy) begin
                    n_status = bac_pkg::ST_BUSY;
                end else if (!r_exists) begin
                    n_status = bac_pkg::ST_BADCPU;
                end else if (bac_pkg::SHARE_W'(r_adm) < div_res.share) begin
                    n_status = bac_pkg::ST_UNDERFLOW;
                end else begin
                    n_write = 1'b1;
                    n_wdata = adm_sub;
                end
            end
            default: begin
                n_allowed = r_exists && (r_limit > ADM_W'(r_reserved));
            end
        endcase
        n_share = n_write ? div_res.share[ADM_W-1:0] : '0;
        n_total = !r_exists ? '0 : n_wdata;
    end

    // Sequence one word through read, share unit and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op       <= i_op;
                        r_cfg_ok   <= i_config_valid;
                        r_dom      <= i_context_domain;
                        r_ctx_busy <= i_context_busy;
                        r_exists   <= exists;
                        r_idx      <= exists ? AW'(i_cpu) : '0;
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_adm <= mem_rdata;
                    if ((r_op == bac_pkg::OP_ADMIT) || (r_op == bac_pkg::OP_RELEASE)) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid   <= 1'b1;
                    r_status  <= n_status;
                    r_share   <= n_share;
                    r_total   <= n_total;
                    r_allowed <= n_allowed;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_share            = r_share;
    assign o_admitted_total   = r_total;
    assign o_dispatch_allowed = r_allowed;

endmodule

// File: design/bac_checker.sv
// ----------------------------------------------------------------------------
// bac_checker
// Port-level checks of the admission control unit, bound to the top level.
// ----------------------------------------------------------------------------
module bac_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [2:0]                   o_status,
    input logic [bac_pkg::ADM_W-1:0]    o_share,
    input logic                         o_dispatch_allowed
);

    // A taken word keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a word was taken");

    // One word at a time: results never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // Failed words report no share
    a_err_no_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != bac_pkg::ST_OK) |-> (o_share == '0))
        else $error("share reported with an error status");

    // Dispatch permission only comes from a query, which is always ok
    a_query_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dispatch_allowed |-> (o_status == bac_pkg::ST_OK) && (o_share == '0))
        else $error("dispatch permission mixed with an admit or release result");

endmodule

bind bandwidth_admission_control_unit bac_checker u_bac_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_status           (o_status),
    .o_share            (o_share),
    .o_dispatch_allowed (o_dispatch_allowed)
);
